FILE: sv/tsst_pkg.sv
// Types and constants shared by the timed set-point schedule table.
package tsst_pkg;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;

  localparam int unsigned TUS_W = 26;
  localparam int unsigned TGT_W = 10;

  localparam logic [15:0] TARGET_MIN  = 16'd200;
  localparam logic [15:0] TARGET_MAX  = 16'd600;
  localparam logic [15:0] TIME_MAX_MS = 16'd60000;
  localparam logic [9:0]  US_PER_MS   = 10'd1000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        edits_allowed;
    logic [15:0] point_time_ms;
    logic [15:0] point_target;
    logic [31:0] sequence_time_us;
    logic        run;
  } in_item_t;

  typedef struct packed {
    logic [9:0] target_now;
    logic [5:0] entry_count;
    logic [4:0] program_position;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [TUS_W-1:0] time_us;
    logic [TGT_W-1:0] target;
  } entry_t;

endpackage

FILE: sv/tsst_mem.sv
// Point table storage with one write port and one registered read port.
module tsst_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  tsst_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output tsst_pkg::entry_t         rdata
);
  import tsst_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/timed_setpoint_schedule_table_top.sv
// Top level: sequencer that scans, shifts and ticks the sorted point table.
// A tick returns its result via S_TICK and the out register; a refused edit, an out-of-range
// set or a clear returns it in the cycle after the transfer. A set or remove walks the table
// with one compare unit, one entry per cycle, then shifts entries one per cycle where needed;
// busy is high meanwhile. After reset the block loads the default point, then accepts items.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module timed_setpoint_schedule_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tsst_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tsst_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [9:0]          cfg_wdata
);
  import tsst_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHUP, S_INSWR, S_RMSH, S_TICK
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [TUS_W-1:0] t_us_r, t_us_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [TGT_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] ins_r, ins_nxt;
  logic [TGT_W-1:0] cfg_r, cfg_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           rd_data;

  logic [31:0]      key;
  logic [31:0]      time_ext;
  logic             cmp_eq;
  logic             cmp_lt;
  logic             is_last;
  logic [IDX_W-1:0] ins_v;
  logic             fin;
  logic [2:0]       status_v;
  entry_t           new_entry;
  entry_t           dflt_entry;

  tsst_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign key      = (item_r.opcode == OP_TICK) ? item_r.sequence_time_us : 32'(t_us_r);
  assign time_ext = 32'(rd_data.time_us);
  assign cmp_eq   = (time_ext == key);
  assign cmp_lt   = (time_ext < key);
  assign is_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign ins_v    = cmp_lt ? (idx_r + IDX_W'(1)) : idx_r;

  assign new_entry.time_us  = t_us_r;
  assign new_entry.target   = TGT_W'(item_r.point_target);
  assign dflt_entry.time_us = '0;
  assign dflt_entry.target  = cfg_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    t_us_nxt      = t_us_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    ins_nxt       = ins_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = new_entry;
    mem_raddr     = '0;
    fin           = 1'b0;
    status_v      = ST_DONE;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_item.opcode == OP_TICK && in_item.run && (CNT_W'(pos_r) < count_r)) begin
          mem_raddr = pos_r;
        end
        if (start) begin
          item_nxt = in_item;
          t_us_nxt = TUS_W'({10'd0, in_item.point_time_ms} * {16'd0, US_PER_MS});
          idx_nxt  = '0;
          if (in_item.opcode == OP_TICK) begin
            if (CNT_W'(pos_r) >= count_r) begin
              pos_nxt = '0;
            end
            state_nxt = S_TICK;
          end else if (!in_item.edits_allowed) begin
            fin      = 1'b1;
            status_v = ST_REFUSED;
          end else if (in_item.opcode == OP_CLEAR) begin
            mem_we    = 1'b1;
            mem_wdata = dflt_entry;
            count_nxt = CNT_W'(1);
            pos_nxt   = '0;
            fin       = 1'b1;
          end else if (in_item.opcode == OP_SET &&
                       (in_item.point_target < TARGET_MIN ||
                        in_item.point_target > TARGET_MAX ||
                        in_item.point_time_ms > TIME_MAX_MS)) begin
            pos_nxt  = '0;
            fin      = 1'b1;
            status_v = ST_RANGE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_eq) begin
          if (item_r.opcode == OP_SET) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            pos_nxt   = '0;
            fin       = 1'b1;
          end else if (!is_last) begin
            mem_raddr = idx_r + IDX_W'(1);
            j_nxt     = idx_r;
            state_nxt = S_RMSH;
          end else begin
            if (count_r == CNT_W'(1)) begin
              mem_we    = 1'b1;
              mem_wdata = dflt_entry;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
            pos_nxt = '0;
            fin     = 1'b1;
          end
        end else if (!cmp_lt || is_last) begin
          pos_nxt = '0;
          if (item_r.opcode == OP_REMOVE) begin
            fin      = 1'b1;
            status_v = ST_NOMATCH;
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            fin      = 1'b1;
            status_v = ST_FULL;
          end else if (CNT_W'(ins_v) == count_r) begin
            mem_we    = 1'b1;
            mem_waddr = ins_v;
            count_nxt = count_r + CNT_W'(1);
            fin       = 1'b1;
          end else begin
            ins_nxt   = ins_v;
            mem_raddr = IDX_W'(count_r - CNT_W'(1));
            j_nxt     = IDX_W'(count_r - CNT_W'(1));
            state_nxt = S_SHUP;
          end
        end else begin
          mem_raddr = idx_r + IDX_W'(1);
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r + IDX_W'(1);
        mem_wdata = rd_data;
        if (j_r == ins_r) begin
          state_nxt = S_INSWR;
        end else begin
          mem_raddr = j_r - IDX_W'(1);
          j_nxt     = j_r - IDX_W'(1);
        end
      end
      S_INSWR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_r;
        count_nxt = count_r + CNT_W'(1);
        pos_nxt   = '0;
        fin       = 1'b1;
      end
      S_RMSH: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = rd_data;
        if ((CNT_W'(j_r) + CNT_W'(2)) < count_r) begin
          mem_raddr = j_r + IDX_W'(2);
          j_nxt     = j_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          pos_nxt   = '0;
          fin       = 1'b1;
        end
      end
      S_TICK: begin
        if (!item_r.run) begin
          cur_nxt = rd_data.target;
          pos_nxt = '0;
        end else if (cmp_lt || cmp_eq) begin
          cur_nxt = rd_data.target;
          if ((CNT_W'(pos_r) + CNT_W'(1)) < count_r) begin
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
        fin = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt            = fin;
    out_nxt                  = out_r;
    if (fin) begin
      out_nxt.target_now       = cur_nxt;
      out_nxt.entry_count      = 6'(count_nxt);
      out_nxt.program_position = 5'(pos_nxt);
      out_nxt.status           = status_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      pos_r       <= '0;
      cur_r       <= '0;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      cur_r       <= cur_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    t_us_r <= t_us_nxt;
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    ins_r  <= ins_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CNT_W'(TABLE_DEPTH))
    else $error("point count out of range");

  a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (CNT_W'(pos_r) < count_r))
    else $error("run position beyond the table");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) || $past(busy)))
    else $error("result strobe without a transfer");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHUP) |-> (j_r >= ins_r))
    else $error("insert shift passed the insert position");
`endif

endmodule
